// File: rtl/run_length_stack_top_defines.svh
// Assertion macros for the run-length stack checker.
`ifndef RUN_LENGTH_STACK_TOP_DEFINES_SVH
`define RUN_LENGTH_STACK_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RLS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define RLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/rls_pkg.sv
// Shared types and codes of the run-length stack.
package rls_pkg;
  localparam int KIND_W = 2;
  localparam int AMT_W = 32;
  localparam int USED_W = 5;
  localparam int STAT_W = 2;
  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;
  localparam logic MODE_PRODUCE = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [AMT_W-1:0] amount;
  } entry_t;

  // Shift command to the cell row
  typedef struct packed {
    logic push;  // shift down, new entry into cell 0
    logic pop;   // shift up
    logic load;  // rewrite cell 0
  } shift_t;
endpackage

// File: rtl/run_length_stack_top.sv
// Top level of the run-length stack: control sequencer, cell row, output register.
//
// A LIFO of (kind, count) runs kept in a row of STACK_DEPTH cells, top in cell 0;
// every push or pop shifts the whole row by one cell. An item is accepted in
// S_IDLE, worked in S_WALK and its result loaded into the output register from
// S_DONE. A consume item stays in S_WALK while it pops whole entries, since the
// remaining amount is compared with the top cell once per cycle and the row
// shifts up once per popped entry. One item is in work at a time; the next can
// be taken as soon as the result sits in the output register, even while that
// result waits for tready.
module run_length_stack_top
  import rls_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode[0], kind[2:1], amount[34:3], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // top_kind[1:0], top_amount[33:2],
                                 // entries_used[38:34], status[40:39], zero pad
);
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic mode;
  logic [KIND_W-1:0] kind;
  logic [AMT_W-1:0] left;
  logic [LVL_W-1:0] fill_level;
  logic [STAT_W-1:0] status;
  shift_t cmd;
  entry_t new_top, top;
  logic out_busy;

  rls_chain #(.DEPTH(STACK_DEPTH)) u_chain (
    .clk(clk), .cmd(cmd), .new_top(new_top), .top(top)
  );

  wire accept = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);

  wire empty = (fill_level == '0);
  wire match = !empty && (top.kind == kind);
  wire full = (fill_level == LVL_W'(STACK_DEPTH));
  wire [AMT_W:0] sum = {1'b0, top.amount} + {1'b0, left};

  // S_WALK step: a produce merges or pushes, a consume pops or trims
  always_comb begin
    cmd = '0;
    new_top.kind = kind;
    new_top.amount = left;
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_WALK;
      S_WALK: begin
        if (mode == MODE_PRODUCE) begin
          state_next = S_DONE;
          if (kind != KIND_BAD) begin
            if (match) begin
              cmd.load = 1'b1;
              new_top.amount = sum[AMT_W] ? '1 : sum[AMT_W-1:0];
            end else if (!full) begin
              cmd.push = 1'b1;
            end
          end
        end else if (empty) begin
          state_next = S_DONE;
        end else if (left >= top.amount) begin
          cmd.pop = 1'b1;
          if (left == top.amount) state_next = S_DONE;
        end else begin
          cmd.load = 1'b1;
          new_top.kind = top.kind;
          new_top.amount = top.amount - left;
          state_next = S_DONE;
        end
      end
      S_DONE: if (!out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill_level <= '0;
    end else begin
      state <= state_next;
      if (cmd.push) fill_level <= fill_level + 1'b1;
      if (cmd.pop) fill_level <= fill_level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode <= s_tdata[0];
      kind <= s_tdata[2:1];
      left <= s_tdata[34:3];
      status <= ST_OK;
    end else if (state == S_WALK) begin
      if (mode == MODE_PRODUCE) begin
        if (kind != KIND_BAD && !match && full) status <= ST_FULL;
      end else if (empty) begin
        status <= ST_UNDER;
      end else if (left > top.amount) begin
        left <= left - top.amount;
      end
    end
  end

  // Output register
  assign out_busy = m_tvalid && !m_tready;
  wire load_out = (state == S_DONE) && !out_busy;
  logic [4:0] used5;
  assign used5 = 5'(fill_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {7'd0, status, used5,
                  empty ? {AMT_W{1'b0}} : top.amount,
                  empty ? {KIND_W{1'b0}} : top.kind};
    end
  end
endmodule

// File: rtl/rls_cell.sv
// One stack cell: holds an entry, shifts to either neighbor.
module rls_cell
  import rls_pkg::*;
(
  input  logic   clk,
  input  shift_t cmd,
  input  entry_t load_val,
  input  entry_t from_above,
  input  entry_t from_below,
  output entry_t value
);
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      value <= from_above;
    end else if (cmd.pop) begin
      value <= from_below;
    end else if (cmd.load) begin
      value <= load_val;
    end
  end
endmodule

// File: rtl/rls_chain.sv
// Row of stack cells; cell 0 is the top of the stack.
module rls_chain
  import rls_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic   clk,
  input  shift_t cmd,
  input  entry_t new_top,
  output entry_t top
);
  entry_t vals [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t above, below;
    shift_t cell_cmd;
    // Only the top cell takes a rewrite; shifts move the whole row
    assign cell_cmd = {cmd.push, cmd.pop, cmd.load && (i == 0)};
    if (i == 0) begin : g_first
      assign above = new_top;
    end else begin : g_mid
      assign above = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = vals[i];
    end else begin : g_inner
      assign below = vals[i+1];
    end
    rls_cell u_cell (
      .clk(clk), .cmd(cell_cmd), .load_val(new_top),
      .from_above(above), .from_below(below), .value(vals[i])
    );
  end

  assign top = vals[0];
endmodule

// File: rtl/rls_checker.sv
// Port-level checker for the run-length stack, bound to the top level.
`include "run_length_stack_top_defines.svh"
module rls_checker
  import rls_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  `RLS_ASSERT(a_hold, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)), "result dropped")
  `RLS_ASSERT(a_empty_zero, m_tvalid && m_tdata[38:34] == 5'd0, m_tdata[33:0] == 34'd0, "empty top not zero")
  `RLS_ASSERT(a_under_empty, m_tvalid && m_tdata[40:39] == ST_UNDER, m_tdata[38:34] == 5'd0, "underflow left entries")
  `RLS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
endmodule

bind run_length_stack_top rls_checker u_rls_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
